FILE: sv/clt_pkg.sv
`default_nettype none
package clt_pkg;

   localparam int MAX_TOKENS = 1024;
   localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
   localparam int IDX_W      = 10;
   localparam int TOT_W      = 11;
   localparam int MAX_RES    = 4;
   localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_TOKEN_END = 2'd1,
      KIND_LINE_DONE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_PLAIN   = 3'd1,
      MODE_QUOTED  = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_STOPPED = 3'd4
   } mode_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         ch;
      logic [IDX_W-1:0]   idx;
      logic [TOT_W-1:0]   total;
   } result_type;

   // index of the open token: count minus one, cut to the index field
   function automatic logic [IDX_W-1:0] idx_of(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt - CNT_W'(1));
      return wide[IDX_W-1:0];
   endfunction

   function automatic logic [TOT_W-1:0] total_of(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[TOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: sv/command_line_tokenizer_unit.sv
// The first result is registered and offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle when not stalled; a byte yields up to four
// results, which leave through a four-slot result shift buffer one per cycle
// while rsp_tready is high. A new byte waits while more than one
// result is buffered, or while the last one is buffered and not taken.
// Reset (synchronous, active high) empties the buffer and clears scan state.
`default_nettype none
module command_line_tokenizer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_line
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] out_char, [17:8] token_index,
                                         // [28:18] token_total, rest zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last_of_run
);
   import clt_pkg::*;

   mode_type               mode_ff, mode_in;
   logic                   slash_ff, slash_in;
   logic                   star_ff, star_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   result_type             slot_ff [MAX_RES];
   logic [RES_CNT_W-1:0]   left_ff;

   result_type             res [MAX_RES];
   logic [RES_CNT_W-1:0]   nres;
   logic                   accept, pop;

   assign rsp_tvalid = (left_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (left_ff == '0) || ((left_ff == RES_CNT_W'(1)) && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tuser = slot_ff[0].kind;
   assign rsp_tdata = {3'b000, slot_ff[0].total, slot_ff[0].idx, slot_ff[0].ch};
   assign rsp_tlast = (left_ff == RES_CNT_W'(1));

   always_comb begin
      logic [7:0]  c;
      logic        fin;
      logic        done;
      c    = req_tdata;
      fin  = (c == 8'h00) || req_tlast;
      done = 1'b0;
      mode_in  = mode_ff;
      slash_in = slash_ff;
      star_in  = star_ff;
      cnt_in   = cnt_ff;
      nres     = '0;
      for (int i = 0; i < MAX_RES; i++) begin
         res[i] = '0;
      end

      if (c != 8'h00) begin
         if (slash_in) begin
            if (c == CH_SLASH) begin
               if (mode_in == MODE_PLAIN) begin
                  res[nres[1:0]] = '{KIND_TOKEN_END, 8'h00, idx_of(cnt_in), '0};
                  nres = nres + RES_CNT_W'(1);
               end
               mode_in  = MODE_STOPPED;
               slash_in = 1'b0;
               done     = 1'b1;
            end else if (c == CH_STAR) begin
               slash_in = 1'b0;
               done     = 1'b1;
               if (mode_in == MODE_PLAIN) begin
                  res[nres[1:0]] = '{KIND_TOKEN_END, 8'h00, idx_of(cnt_in), '0};
                  nres = nres + RES_CNT_W'(1);
               end
               if (mode_in == MODE_PLAIN && cnt_in >= CNT_W'(MAX_TOKENS)) begin
                  mode_in = MODE_STOPPED;
               end else begin
                  mode_in = MODE_COMMENT;
                  star_in = 1'b1;
               end
            end else begin
               // held slash turns into a token character
               if (mode_in == MODE_BETWEEN) begin
                  cnt_in  = cnt_in + CNT_W'(1);
                  mode_in = MODE_PLAIN;
               end
               res[nres[1:0]] = '{KIND_BYTE, CH_SLASH, idx_of(cnt_in), '0};
               nres     = nres + RES_CNT_W'(1);
               slash_in = 1'b0;
            end
         end

         if (!done) begin
            case (mode_in)
               MODE_BETWEEN: begin
                  if (c <= CH_SPACE || c[7]) begin
                     mode_in = MODE_BETWEEN;
                  end else if (c == CH_QUOTE) begin
                     cnt_in  = cnt_in + CNT_W'(1);
                     mode_in = MODE_QUOTED;
                  end else if (c == CH_SLASH) begin
                     slash_in = 1'b1;
                  end else begin
                     cnt_in  = cnt_in + CNT_W'(1);
                     mode_in = MODE_PLAIN;
                     res[nres[1:0]] = '{KIND_BYTE, c, idx_of(cnt_in), '0};
                     nres = nres + RES_CNT_W'(1);
                  end
               end
               MODE_PLAIN: begin
                  if (c <= CH_SPACE || c[7]) begin
                     res[nres[1:0]] = '{KIND_TOKEN_END, 8'h00, idx_of(cnt_in), '0};
                     nres    = nres + RES_CNT_W'(1);
                     mode_in = (cnt_in >= CNT_W'(MAX_TOKENS)) ? MODE_STOPPED : MODE_BETWEEN;
                  end else if (c == CH_QUOTE) begin
                     // quote closes the plain token and opens a quoted one, unless the token limit stops the scan
                     res[nres[1:0]] = '{KIND_TOKEN_END, 8'h00, idx_of(cnt_in), '0};
                     nres = nres + RES_CNT_W'(1);
                     if (cnt_in >= CNT_W'(MAX_TOKENS)) begin
                        mode_in = MODE_STOPPED;
                     end else begin
                        cnt_in  = cnt_in + CNT_W'(1);
                        mode_in = MODE_QUOTED;
                     end
                  end else if (c == CH_SLASH) begin
                     slash_in = 1'b1;
                  end else begin
                     res[nres[1:0]] = '{KIND_BYTE, c, idx_of(cnt_in), '0};
                     nres = nres + RES_CNT_W'(1);
                  end
               end
               MODE_QUOTED: begin
                  if (c == CH_QUOTE) begin
                     res[nres[1:0]] = '{KIND_TOKEN_END, 8'h00, idx_of(cnt_in), '0};
                     nres    = nres + RES_CNT_W'(1);
                     mode_in = (cnt_in >= CNT_W'(MAX_TOKENS)) ? MODE_STOPPED : MODE_BETWEEN;
                  end else begin
                     res[nres[1:0]] = '{KIND_BYTE, c, idx_of(cnt_in), '0};
                     nres = nres + RES_CNT_W'(1);
                  end
               end
               MODE_COMMENT: begin
                  if (star_in && c == CH_SLASH) begin
                     mode_in = MODE_BETWEEN;
                     star_in = 1'b0;
                  end else begin
                     star_in = (c == CH_STAR);
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end

      if (fin) begin
         if (slash_in) begin
            if (mode_in == MODE_BETWEEN) begin
               cnt_in  = cnt_in + CNT_W'(1);
               mode_in = MODE_PLAIN;
            end
            res[nres[1:0]] = '{KIND_BYTE, CH_SLASH, idx_of(cnt_in), '0};
            nres = nres + RES_CNT_W'(1);
         end
         if (mode_in == MODE_PLAIN || mode_in == MODE_QUOTED) begin
            res[nres[1:0]] = '{KIND_TOKEN_END, 8'h00, idx_of(cnt_in), '0};
            nres = nres + RES_CNT_W'(1);
         end
         res[nres[1:0]] = '{KIND_LINE_DONE, 8'h00, '0, total_of(cnt_in)};
         nres     = nres + RES_CNT_W'(1);
         mode_in  = MODE_BETWEEN;
         slash_in = 1'b0;
         star_in  = 1'b0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BETWEEN;
         slash_ff <= 1'b0;
         star_ff  <= 1'b0;
         cnt_ff   <= '0;
         left_ff  <= '0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            slash_ff <= slash_in;
            star_ff  <= star_in;
            cnt_ff   <= cnt_in;
         end
         if (accept && nres != '0) begin
            left_ff <= nres;
         end else if (pop) begin
            left_ff <= left_ff - RES_CNT_W'(1);
         end
      end
   end

   // result buffer: slot 0 is presented, later slots shift down on each pop
   always_ff @(posedge clock) begin
      if (accept && nres != '0) begin
         for (int i = 0; i < MAX_RES; i++) begin
            slot_ff[i] <= res[i];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/clt_checker.sv
`default_nettype none
module clt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import clt_pkg::*;

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a line-done item always closes the run of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_LINE_DONE |-> rsp_tlast)
      else $error("line-done item not marked last");

   // token items carry no total, non-byte items carry no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_LINE_DONE |-> rsp_tdata[28:18] == '0)
      else $error("token item carries a total");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tdata[7:0] == 8'h00)
      else $error("non-byte item carries a character");

   // a zero byte ends the line, so its run must produce a line-done item; this checks that a result is offered
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata == 8'h00 |=> rsp_tvalid)
      else $error("zero byte produced no result");

endmodule

bind command_line_tokenizer_unit clt_checker u_clt_checker (.*);
`default_nettype wire
